// ----- sv/scdp_pkg.sv -----
// Package for the sparse complex dot product block.
// Holds sizes, op codes and shared types; no dependencies.
`default_nettype none

package scdp_pkg;

    localparam int LIST_DEPTH = 256;
    localparam int ID_BITS    = 32;
    localparam int COEFF_BITS = 16;

    localparam int IDX_W   = $clog2(LIST_DEPTH);
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int ENTRY_W = ID_BITS + 2 * COEFF_BITS;
    localparam int PROD_W  = 2 * COEFF_BITS;
    localparam int SUM_W   = 48;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    // control from the walker to the multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic en;
    } t_mac_ctrl;

endpackage

`default_nettype wire

// ----- sv/scdp_ifs.sv -----
// Valid/ready channel interfaces for the input and result words.
// Depends on scdp_pkg.
`default_nettype none

interface scdp_in_if;
    import scdp_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              op;
    logic [ID_BITS-1:0]           entry_id;
    logic signed [COEFF_BITS-1:0] coeff_re;
    logic signed [COEFF_BITS-1:0] coeff_im;

    modport source (output valid, output op, output entry_id, output coeff_re,
                    output coeff_im, input ready);
    modport sink   (input valid, input op, input entry_id, input coeff_re,
                    input coeff_im, output ready);
endinterface

interface scdp_out_if;
    import scdp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] sum_re;
    logic signed [SUM_W-1:0] sum_im;
    logic [CNT_W-1:0]        matches_res;
    logic                    overflow;

    modport source (output valid, output sum_re, output sum_im, output matches_res,
                    output overflow, input ready);
    modport sink   (input valid, input sum_re, input sum_im, input matches_res,
                    input overflow, output ready);
endinterface

`default_nettype wire

// ----- sv/scdp_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
// No package dependency.
`default_nettype none

module scdp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/scdp_mac.sv -----
// Complex multiply-accumulate of conj(a)*b: one product register stage,
// then a 48-bit accumulator. Depends on scdp_pkg.
`default_nettype none

module scdp_mac (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire scdp_pkg::t_mac_ctrl                      i_ctrl,
    input  wire logic signed [scdp_pkg::COEFF_BITS-1:0]   i_a_re,
    input  wire logic signed [scdp_pkg::COEFF_BITS-1:0]   i_a_im,
    input  wire logic signed [scdp_pkg::COEFF_BITS-1:0]   i_b_re,
    input  wire logic signed [scdp_pkg::COEFF_BITS-1:0]   i_b_im,
    output logic signed [scdp_pkg::SUM_W-1:0]             o_sum_re,
    output logic signed [scdp_pkg::SUM_W-1:0]             o_sum_im,
    output logic                                          o_busy
);
    import scdp_pkg::*;

    logic                     r_pvalid;
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [SUM_W-1:0]  r_acc_re, r_acc_im;
    logic signed [SUM_W-1:0]  n_acc_re, n_acc_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_ctrl.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_rr <= i_a_re * i_b_re;
        r_p_ii <= i_a_im * i_b_im;
        r_p_ri <= i_a_re * i_b_im;
        r_p_ir <= i_a_im * i_b_re;
    end

    always_comb begin
        n_acc_re = r_acc_re;
        n_acc_im = r_acc_im;
        if (i_ctrl.clr) begin
            n_acc_re = '0;
            n_acc_im = '0;
        end else if (r_pvalid) begin
            n_acc_re = r_acc_re + SUM_W'(r_p_rr) + SUM_W'(r_p_ii);
            n_acc_im = r_acc_im + SUM_W'(r_p_ri) - SUM_W'(r_p_ir);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_re <= n_acc_re;
        r_acc_im <= n_acc_im;
    end

    assign o_sum_re = r_acc_re;
    assign o_sum_im = r_acc_im;
    assign o_busy   = r_pvalid;

endmodule

`default_nettype wire

// ----- sv/sparse_complex_dot_product.sv -----
// Sparse complex dot product top level: list RAMs, merge-walk sequencer and
// output register. Depends on scdp_pkg, scdp_ifs, scdp_ram and scdp_mac.
//
// Two lists of up to 256 entries (id plus Q1.15 complex coefficient) sit in
// two RAMs. Appends (op 0 to the first list, op 1 to the second) give no
// result; an append to a full list is dropped and sets the overflow flag. A
// compute (op 2) walks both lists from their heads, one step per cycle,
// adding conj(a)*b on equal ids, and returns sum, match count and overflow,
// then empties both lists. The walk reads one RAM entry per list per cycle,
// and a compute keeps the input stalled until its result is loaded into the
// output register. The result sits in that register; appends are taken while
// it waits, a following compute finishes its walk and then waits for that
// register to free up.
`default_nettype none

module sparse_complex_dot_product (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    scdp_in_if.sink     i_in,
    scdp_out_if.source  o_out
);
    import scdp_pkg::*;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cnt1, n_cnt1, r_cnt2, n_cnt2;
    logic [CNT_W-1:0]         r_i1, n_i1, r_i2, n_i2;
    logic [CNT_W-1:0]         r_matches, n_matches;
    logic                     r_drop, n_drop;
    logic                     r_out_valid, n_out_valid;
    logic signed [SUM_W-1:0]  r_out_re, r_out_im;
    logic [CNT_W-1:0]         r_out_matches;
    logic                     r_out_ovf;
    logic                     load_out;

    logic                     in_acc;
    logic                     we1, we2;
    logic [ENTRY_W-1:0]       wdata, q1, q2;
    logic [ID_BITS-1:0]       id1, id2;
    logic                     walk_done;
    t_mac_ctrl                mac_ctrl;
    logic signed [SUM_W-1:0]  sum_re, sum_im;
    logic                     mac_busy;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign wdata      = {i_in.entry_id, i_in.coeff_re, i_in.coeff_im};

    // read address follows the next walk index so data lines up with r_i1/r_i2
    scdp_ram #(.WIDTH(ENTRY_W), .DEPTH(LIST_DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_cnt1[IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_i1[IDX_W-1:0]),
        .o_rdata (q1)
    );

    scdp_ram #(.WIDTH(ENTRY_W), .DEPTH(LIST_DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (r_cnt2[IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (n_i2[IDX_W-1:0]),
        .o_rdata (q2)
    );

    assign id1 = q1[ENTRY_W-1 -: ID_BITS];
    assign id2 = q2[ENTRY_W-1 -: ID_BITS];
    assign walk_done = (r_i1 >= r_cnt1) || (r_i2 >= r_cnt2);

    scdp_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_a_re   (q1[2*COEFF_BITS-1 -: COEFF_BITS]),
        .i_a_im   (q1[COEFF_BITS-1:0]),
        .i_b_re   (q2[2*COEFF_BITS-1 -: COEFF_BITS]),
        .i_b_im   (q2[COEFF_BITS-1:0]),
        .o_sum_re (sum_re),
        .o_sum_im (sum_im),
        .o_busy   (mac_busy)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt1    = r_cnt1;
        n_cnt2    = r_cnt2;
        n_i1      = r_i1;
        n_i2      = r_i2;
        n_matches = r_matches;
        n_drop    = r_drop;
        mac_ctrl  = '0;
        we1       = 1'b0;
        we2       = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.op)
                        OP_APPEND_A: begin
                            if (r_cnt1 == CNT_W'(LIST_DEPTH)) begin
                                n_drop = 1'b1;
                            end else begin
                                we1    = 1'b1;
                                n_cnt1 = r_cnt1 + 1'b1;
                            end
                        end
                        OP_APPEND_B: begin
                            if (r_cnt2 == CNT_W'(LIST_DEPTH)) begin
                                n_drop = 1'b1;
                            end else begin
                                we2    = 1'b1;
                                n_cnt2 = r_cnt2 + 1'b1;
                            end
                        end
                        OP_COMPUTE: begin
                            n_state      = S_WALK;
                            n_i1         = '0;
                            n_i2         = '0;
                            n_matches    = '0;
                            mac_ctrl.clr = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = S_FLUSH;
                end else if (id1 == id2) begin
                    mac_ctrl.en = 1'b1;
                    n_i1        = r_i1 + 1'b1;
                    n_i2        = r_i2 + 1'b1;
                    n_matches   = r_matches + 1'b1;
                end else if (id1 < id2) begin
                    n_i1 = r_i1 + 1'b1;
                end else begin
                    n_i2 = r_i2 + 1'b1;
                end
            end
            S_FLUSH: begin
                if (!mac_busy && (!r_out_valid || o_out.ready)) begin
                    load_out = 1'b1;
                    n_cnt1   = '0;
                    n_cnt2   = '0;
                    n_drop   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = load_out || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt1      <= '0;
            r_cnt2      <= '0;
            r_i1        <= '0;
            r_i2        <= '0;
            r_matches   <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt1      <= n_cnt1;
            r_cnt2      <= n_cnt2;
            r_i1        <= n_i1;
            r_i2        <= n_i2;
            r_matches   <= n_matches;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_re      <= sum_re;
            r_out_im      <= sum_im;
            r_out_matches <= r_matches;
            r_out_ovf     <= r_drop;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.sum_re      = r_out_re;
    assign o_out.sum_im      = r_out_im;
    assign o_out.matches_res = r_out_matches;
    assign o_out.overflow    = r_out_ovf;

endmodule

`default_nettype wire

// ----- sv/scdp_checker.sv -----
// Port-level checker for sparse_complex_dot_product, bound to the top level.
// Depends on scdp_pkg.
`default_nettype none

module scdp_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [scdp_pkg::OP_W-1:0]     in_op,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [scdp_pkg::SUM_W-1:0]    out_sum_re,
    input wire logic [scdp_pkg::SUM_W-1:0]    out_sum_im,
    input wire logic [scdp_pkg::CNT_W-1:0]    out_matches,
    input wire logic                          out_overflow
);
    import scdp_pkg::*;

    // a result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_sum_re) && $stable(out_sum_im)
            && $stable(out_matches) && $stable(out_overflow))
        else $error("stalled result word changed");

    // a compute word stalls the input while the walk runs
    a_compute_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_op == OP_COMPUTE |=> !in_ready)
        else $error("input ready right after a compute word");

    // a new result only appears at the end of a walk, never after an append
    a_result_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a walk");

endmodule

bind sparse_complex_dot_product scdp_checker u_scdp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_valid     (i_in.valid),
    .in_ready     (i_in.ready),
    .in_op        (i_in.op),
    .out_valid    (o_out.valid),
    .out_ready    (o_out.ready),
    .out_sum_re   (o_out.sum_re),
    .out_sum_im   (o_out.sum_im),
    .out_matches  (o_out.matches_res),
    .out_overflow (o_out.overflow)
);

`default_nettype wire

// ----- tb/sv/tb_sparse_complex_dot_product.sv -----
// Self-checking testbench for sparse_complex_dot_product: drives list appends and
// computes, predicts each dot-product word and compares it field by field.
// Depends on scdp_pkg, scdp_ifs and the sparse_complex_dot_product RTL.

module tb_sparse_complex_dot_product;
    timeunit 1ns;
    timeprecision 1ps;

    import scdp_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam logic signed [COEFF_BITS-1:0] CF_MIN = 16'sh8000;
    localparam logic signed [COEFF_BITS-1:0] CF_MAX = 16'sh7FFF;
    localparam logic [ID_BITS-1:0] ID_TOP = 32'hFFFF_FFFF;
    localparam int ITEM_TARGET   = 1600;
    localparam int MIN_COMPUTES  = 40;
    localparam int HOLD_CYCLES   = 1200;
    localparam int DRAIN_CYCLES  = 600;
    localparam int STALL_LIMIT   = 4000;

    typedef struct {
        logic [ID_BITS-1:0]           id;
        logic signed [COEFF_BITS-1:0] re;
        logic signed [COEFF_BITS-1:0] im;
    } t_list_entry;

    typedef struct {
        logic [SUM_W-1:0] sum_re;
        logic [SUM_W-1:0] sum_im;
        logic [CNT_W-1:0] match_cnt;
        logic             overflow;
    } t_dot_result;

    class dot_product_scoreboard;
        t_list_entry first_list[$];
        t_list_entry second_list[$];
        bit          dropped;
        t_dot_result pending_sums[$];
        int          errors;

        function new();
            dropped = 0;
            errors  = 0;
        endfunction

        function int pending();
            return pending_sums.size();
        endfunction

        // merge walk over both lists, as the block does on a compute
        function void walk_lists();
            t_dot_result r;
            longint acc_re;
            longint acc_im;
            int i1;
            int i2;
            int hits;
            acc_re = 0;
            acc_im = 0;
            i1 = 0;
            i2 = 0;
            hits = 0;
            while (i1 < first_list.size() && i2 < second_list.size()) begin
                if (first_list[i1].id == second_list[i2].id) begin
                    acc_re += longint'(first_list[i1].re) * longint'(second_list[i2].re)
                            + longint'(first_list[i1].im) * longint'(second_list[i2].im);
                    acc_im += longint'(first_list[i1].re) * longint'(second_list[i2].im)
                            - longint'(first_list[i1].im) * longint'(second_list[i2].re);
                    hits++;
                    i1++;
                    i2++;
                end else if (first_list[i1].id < second_list[i2].id) begin
                    i1++;
                end else begin
                    i2++;
                end
            end
            r.sum_re    = acc_re[SUM_W-1:0];
            r.sum_im    = acc_im[SUM_W-1:0];
            r.match_cnt = hits[CNT_W-1:0];
            r.overflow  = dropped;
            pending_sums = {pending_sums, r};
            first_list.delete();
            second_list.delete();
            dropped = 0;
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [ID_BITS-1:0] id,
                                logic signed [COEFF_BITS-1:0] re,
                                logic signed [COEFF_BITS-1:0] im);
            t_list_entry e;
            e.id = id;
            e.re = re;
            e.im = im;
            case (op)
                OP_APPEND_A: begin
                    if (first_list.size() >= LIST_DEPTH) dropped = 1;
                    else first_list = {first_list, e};
                end
                OP_APPEND_B: begin
                    if (second_list.size() >= LIST_DEPTH) dropped = 1;
                    else second_list = {second_list, e};
                end
                OP_COMPUTE: walk_lists();
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [SUM_W-1:0] exp_v,
                                    logic [SUM_W-1:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [SUM_W-1:0] sum_re, logic [SUM_W-1:0] sum_im,
                                   logic [CNT_W-1:0] act_matches, logic overflow);
            t_dot_result e;
            if (pending_sums.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, got sum_re %h sum_im %h matches %0d ovf %b",
                         $time, sum_re, sum_im, act_matches, overflow);
                return;
            end
            e = pending_sums.pop_front();
            compare_field("sum_re", e.sum_re, sum_re);
            compare_field("sum_im", e.sum_im, sum_im);
            compare_field("matches", SUM_W'(e.match_cnt), SUM_W'(act_matches));
            compare_field("overflow", SUM_W'(e.overflow), SUM_W'(overflow));
        endfunction

        function void drain_check();
            if (pending_sums.size() != 0) begin
                errors += pending_sums.size();
                $display("%0t: %0d expected result words never arrived, expected sum_re %h",
                         $time, pending_sums.size(), pending_sums[0].sum_re);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    scdp_in_if  in_if();
    scdp_out_if out_if();

    sparse_complex_dot_product uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    dot_product_scoreboard sb;
    int words_sent;
    int computes_sent;
    int results_taken;
    bit send_quiet;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [COEFF_BITS-1:0] rand_coeff();
        case ($urandom_range(0, 9))
            0: return CF_MIN;
            1: return CF_MAX;
            default: return COEFF_BITS'($urandom);
        endcase
    endfunction

    // one word on the input channel; valid stays high across back-to-back words
    task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_BITS-1:0] id,
                             input logic signed [COEFF_BITS-1:0] re,
                             input logic signed [COEFF_BITS-1:0] im);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.op       <= op;
        in_if.entry_id <= id;
        in_if.coeff_re <= re;
        in_if.coeff_im <= im;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_word(op, id, re, im);
        if (op != OP_IGNORED) words_sent++;
        if (op == OP_COMPUTE) computes_sent++;
    endtask

    task automatic send_compute();
        send_word(OP_COMPUTE, ID_BITS'($urandom), COEFF_BITS'($urandom),
                  COEFF_BITS'($urandom));
    endtask

    task automatic send_noise();
        send_word(OP_IGNORED, ID_BITS'($urandom), COEFF_BITS'($urandom),
                  COEFF_BITS'($urandom));
    endtask

    // ascending id pool, each id lands in either list, both or neither
    task automatic run_sorted_lists();
        logic [ID_BITS-1:0] base;
        logic [ID_BITS-1:0] id;
        int n;
        int stride;
        bit in_a;
        bit in_b;
        n      = $urandom_range(1, 16);
        stride = $urandom_range(1, 1000);
        base   = $urandom_range(0, ID_TOP - 16000);
        for (int k = 0; k < n; k++) begin
            id   = base + k * stride;
            in_a = ($urandom_range(0, 2) != 0);
            in_b = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 1)) begin
                if (in_a) send_word(OP_APPEND_A, id, rand_coeff(), rand_coeff());
                if (in_b) send_word(OP_APPEND_B, id, rand_coeff(), rand_coeff());
            end else begin
                if (in_b) send_word(OP_APPEND_B, id, rand_coeff(), rand_coeff());
                if (in_a) send_word(OP_APPEND_A, id, rand_coeff(), rand_coeff());
            end
            if ($urandom_range(0, 19) == 0) send_noise();
        end
        send_compute();
    endtask

    // unsorted lists over a narrow id window so that matches still happen
    task automatic run_unsorted_lists();
        logic [ID_BITS-1:0] base;
        int n;
        base = $urandom;
        n    = $urandom_range(0, 24);
        for (int k = 0; k < n; k++) begin
            send_word($urandom_range(0, 1) ? OP_APPEND_A : OP_APPEND_B,
                      base + $urandom_range(0, 7), rand_coeff(), rand_coeff());
        end
        send_compute();
    endtask

    // long shared ascending runs; lengths past LIST_DEPTH overflow the list
    task automatic fill_lists(input int n_a, input int n_b);
        logic [ID_BITS-1:0] base;
        base = $urandom_range(0, ID_TOP - 300);
        for (int k = 0; k < n_a || k < n_b; k++) begin
            if (k < n_a) send_word(OP_APPEND_A, base + k, rand_coeff(), rand_coeff());
            if (k < n_b) send_word(OP_APPEND_B, base + k, rand_coeff(), rand_coeff());
        end
        send_compute();
    endtask

    initial begin : stimulus
        int seq;
        sb = new();
        words_sent     = 0;
        computes_sent  = 0;
        send_quiet     = 1'b1;
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.op       <= OP_APPEND_A;
        in_if.entry_id <= '0;
        in_if.coeff_re <= '0;
        in_if.coeff_im <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty lists, ignored op, extremes of ids and coefficients
        send_compute();
        send_word(OP_IGNORED, ID_TOP, CF_MIN, CF_MIN);
        send_word(OP_APPEND_A, '0, CF_MIN, CF_MIN);
        send_word(OP_APPEND_A, 32'd5, CF_MAX, CF_MIN);
        send_word(OP_APPEND_A, ID_TOP, CF_MAX, CF_MAX);
        send_word(OP_APPEND_B, '0, CF_MIN, CF_MAX);
        send_word(OP_APPEND_B, 32'd3, 16'sd1, -16'sd1);
        send_word(OP_APPEND_B, 32'd5, CF_MIN, CF_MIN);
        send_word(OP_IGNORED, '0, '0, '0);
        send_word(OP_APPEND_B, ID_TOP, CF_MIN, CF_MAX);
        send_compute();
        // one side empty
        send_word(OP_APPEND_A, 32'd7, CF_MAX, CF_MIN);
        send_compute();
        send_word(OP_APPEND_B, 32'd7, CF_MIN, CF_MAX);
        send_compute();
        // unsorted first list, ids compared unsigned
        send_word(OP_APPEND_A, 32'h8000_0000, CF_MAX, 16'sd3);
        send_word(OP_APPEND_A, 32'd2, 16'sd100, -16'sd7);
        send_word(OP_APPEND_A, 32'h8000_0000, CF_MIN, CF_MAX);
        send_word(OP_APPEND_B, 32'd2, -16'sd9, 16'sd4);
        send_word(OP_APPEND_B, 32'h8000_0000, CF_MAX, CF_MAX);
        send_compute();

        send_quiet = 1'b0;
        seq = 0;
        while (words_sent < ITEM_TARGET || computes_sent < MIN_COMPUTES) begin
            if ($urandom_range(0, 3) == 0) send_quiet = !send_quiet;
            case (seq)
                4:  fill_lists(LIST_DEPTH + 2, 30);
                10: fill_lists(12, LIST_DEPTH + 1);
                17: fill_lists(LIST_DEPTH, LIST_DEPTH);
                default: begin
                    if ($urandom_range(0, 7) == 0) run_unsorted_lists();
                    else run_sorted_lists();
                end
            endcase
            seq++;
        end
        in_if.valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.drain_check();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin : result_sink
        int stall;
        bit quiet;
        bit held;
        quiet = 1'b1;
        held  = 1'b0;
        results_taken = 0;
        out_if.ready <= 1'b0;
        // wait for an edge that sees reset released
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if ($urandom_range(0, 7) == 0) quiet = !quiet;
            stall = quiet ? 0 : $urandom_range(0, 19);
            // one long hold so the output register fills and the input backs up
            if (!held && results_taken == 6) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            sb.check_result(out_if.sum_re, out_if.sum_im, out_if.matches_res,
                            out_if.overflow);
            results_taken++;
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
